>>> design/qpr_pkg.sv
package qpr_pkg;

    // Component format: signed Q2.14
    localparam int COMP_W    = 16;
    localparam int FRAC_BITS = 14;

    // Operands carry one extra bit so a negated most-negative value stays exact
    localparam int OPND_W = COMP_W + 1;
    localparam int PROD_W = 2 * OPND_W;
    // Sum of four products plus rounding headroom
    localparam int ACC_W  = PROD_W + 3;

    // Operation codes
    localparam logic OP_PRODUCT = 1'b0;
    localparam logic OP_ROTATE  = 1'b1;

    // Component indexes
    localparam int IDX_X = 0;
    localparam int IDX_Y = 1;
    localparam int IDX_Z = 2;
    localparam int IDX_W = 3;

    typedef logic signed [COMP_W-1:0] comp_t;
    typedef logic signed [OPND_W-1:0] opnd_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [ACC_W-1:0]  acc_t;

    typedef struct packed {
        logic  op;
        comp_t a_x;
        comp_t a_y;
        comp_t a_z;
        comp_t a_w;
        comp_t b_x;
        comp_t b_y;
        comp_t b_z;
        comp_t b_w;
    } cmd_t;

    typedef struct packed {
        comp_t r_x;
        comp_t r_y;
        comp_t r_z;
        comp_t r_w;
        logic  saturated;
    } res_t;

endpackage

>>> design/quaternion_product_and_rotate.sv
// Channel  Signals                        Payload
// -------  -----------------------------  ------------------------------------
// cmd      cmd_valid / cmd_ready / cmd    op, a_x..a_w, b_x..b_w (cmd_t)
// res      res_valid / res_ready / res    r_x..r_w, saturated (res_t)
//
// One transaction per cycle while res is not stalled.
// Two 3-stage product units in series (a*b or a*v, then t*conj(a)), plus the output register.
// A stalled res holds the whole pipeline in place; cmd_ready drops with it.
// Reset clears the valid bits only.
module quaternion_product_and_rotate
    import qpr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic cmd_valid,
    output logic cmd_ready,
    input  cmd_t cmd,
    output logic res_valid,
    input  logic res_ready,
    output res_t res
);

    logic       advance;
    opnd_t      u1_a [4];
    opnd_t      u1_b [4];
    logic       u1_valid;
    comp_t      u1_r [4];
    logic [3:0] u1_sat;
    opnd_t      u2_a [4];
    opnd_t      u2_b [4];
    logic       u2_valid;
    comp_t      u2_r [4];
    logic [3:0] u2_sat;

    logic [5:0] op_dly_reg;
    comp_t      a_dly_reg   [3][4];
    comp_t      r1_dly_reg  [3][4];
    logic [2:0] sat1_dly_reg;
    logic       res_valid_reg;
    res_t       res_reg;
    res_t       res_next;

    // Global stall: move only when the output slot is free or being taken
    assign advance   = !res_valid_reg || res_ready;
    assign cmd_ready = advance;

    // First product: a * b, with b_w forced to zero for a rotation
    always_comb
    begin
        u1_a[IDX_X] = OPND_W'(cmd.a_x);
        u1_a[IDX_Y] = OPND_W'(cmd.a_y);
        u1_a[IDX_Z] = OPND_W'(cmd.a_z);
        u1_a[IDX_W] = OPND_W'(cmd.a_w);
        u1_b[IDX_X] = OPND_W'(cmd.b_x);
        u1_b[IDX_Y] = OPND_W'(cmd.b_y);
        u1_b[IDX_Z] = OPND_W'(cmd.b_z);
        u1_b[IDX_W] = (cmd.op == OP_ROTATE) ? '0 : OPND_W'(cmd.b_w);
    end

    qpr_hprod u_prod1 (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (advance),
        .in_valid  (cmd_valid),
        .a         (u1_a),
        .b         (u1_b),
        .out_valid (u1_valid),
        .r         (u1_r),
        .sat       (u1_sat)
    );

    // Second product: t * conj(a), negation done at operand width
    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            u2_a[k] = OPND_W'(u1_r[k]);
        end
        u2_b[IDX_X] = -OPND_W'(a_dly_reg[2][IDX_X]);
        u2_b[IDX_Y] = -OPND_W'(a_dly_reg[2][IDX_Y]);
        u2_b[IDX_Z] = -OPND_W'(a_dly_reg[2][IDX_Z]);
        u2_b[IDX_W] = OPND_W'(a_dly_reg[2][IDX_W]);
    end

    qpr_hprod u_prod2 (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (advance),
        .in_valid  (u1_valid),
        .a         (u2_a),
        .b         (u2_b),
        .out_valid (u2_valid),
        .r         (u2_r),
        .sat       (u2_sat)
    );

    // Side data riding alongside the product units
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            op_dly_reg      <= {op_dly_reg[4:0], cmd.op};
            a_dly_reg[0]    <= '{cmd.a_x, cmd.a_y, cmd.a_z, cmd.a_w};
            a_dly_reg[1]    <= a_dly_reg[0];
            a_dly_reg[2]    <= a_dly_reg[1];
            r1_dly_reg[0]   <= u1_r;
            r1_dly_reg[1]   <= r1_dly_reg[0];
            r1_dly_reg[2]   <= r1_dly_reg[1];
            sat1_dly_reg    <= {sat1_dly_reg[1:0], |u1_sat};
            res_reg         <= res_next;
        end
    end

    // Result select; a rotation drops w and its flag
    always_comb
    begin
        if (op_dly_reg[5] == OP_PRODUCT)
        begin
            res_next.r_x       = r1_dly_reg[2][IDX_X];
            res_next.r_y       = r1_dly_reg[2][IDX_Y];
            res_next.r_z       = r1_dly_reg[2][IDX_Z];
            res_next.r_w       = r1_dly_reg[2][IDX_W];
            res_next.saturated = sat1_dly_reg[2];
        end
        else
        begin
            res_next.r_x       = u2_r[IDX_X];
            res_next.r_y       = u2_r[IDX_Y];
            res_next.r_z       = u2_r[IDX_Z];
            res_next.r_w       = '0;
            res_next.saturated = sat1_dly_reg[2] | (|u2_sat[2:0]);
        end
    end

    // Output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            res_valid_reg <= u2_valid;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

>>> design/qpr_hprod.sv
// Three-stage Hamilton product r = a * b: multiply, sum, round and saturate.
module qpr_hprod
    import qpr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       en,
    input  logic       in_valid,
    input  opnd_t      a [4],
    input  opnd_t      b [4],
    output logic       out_valid,
    output comp_t      r [4],
    output logic [3:0] sat
);

    localparam acc_t  RND_HALF = acc_t'(1) <<< (FRAC_BITS - 1);
    localparam comp_t MAX_VAL  = {1'b0, {(COMP_W-1){1'b1}}};
    localparam comp_t MIN_VAL  = {1'b1, {(COMP_W-1){1'b0}}};

    logic       mul_valid_reg;
    logic       sum_valid_reg;
    logic       out_valid_reg;
    prod_t      prod_reg  [4][4];
    prod_t      prod_next [4][4];
    acc_t       acc_reg   [4];
    acc_t       acc_next  [4];
    acc_t       rnd       [4];
    acc_t       shr       [4];
    comp_t      r_reg     [4];
    comp_t      r_next    [4];
    logic [3:0] sat_reg;
    logic [3:0] sat_next;

    // Stage 1: sixteen products; stage 2 subtracts the last term of rows x, y, z and the last three of row w
    always_comb
    begin
        prod_next[IDX_X][0] = PROD_W'(a[IDX_W]) * PROD_W'(b[IDX_X]);
        prod_next[IDX_X][1] = PROD_W'(a[IDX_X]) * PROD_W'(b[IDX_W]);
        prod_next[IDX_X][2] = PROD_W'(a[IDX_Y]) * PROD_W'(b[IDX_Z]);
        prod_next[IDX_X][3] = PROD_W'(a[IDX_Z]) * PROD_W'(b[IDX_Y]);

        prod_next[IDX_Y][0] = PROD_W'(a[IDX_W]) * PROD_W'(b[IDX_Y]);
        prod_next[IDX_Y][1] = PROD_W'(a[IDX_Y]) * PROD_W'(b[IDX_W]);
        prod_next[IDX_Y][2] = PROD_W'(a[IDX_Z]) * PROD_W'(b[IDX_X]);
        prod_next[IDX_Y][3] = PROD_W'(a[IDX_X]) * PROD_W'(b[IDX_Z]);

        prod_next[IDX_Z][0] = PROD_W'(a[IDX_W]) * PROD_W'(b[IDX_Z]);
        prod_next[IDX_Z][1] = PROD_W'(a[IDX_Z]) * PROD_W'(b[IDX_W]);
        prod_next[IDX_Z][2] = PROD_W'(a[IDX_X]) * PROD_W'(b[IDX_Y]);
        prod_next[IDX_Z][3] = PROD_W'(a[IDX_Y]) * PROD_W'(b[IDX_X]);

        prod_next[IDX_W][0] = PROD_W'(a[IDX_W]) * PROD_W'(b[IDX_W]);
        prod_next[IDX_W][1] = PROD_W'(a[IDX_X]) * PROD_W'(b[IDX_X]);
        prod_next[IDX_W][2] = PROD_W'(a[IDX_Y]) * PROD_W'(b[IDX_Y]);
        prod_next[IDX_W][3] = PROD_W'(a[IDX_Z]) * PROD_W'(b[IDX_Z]);
    end

    // Stage 2: signed sums; x, y, z are + + + -, w is + - - -
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            acc_next[k] = ACC_W'(prod_reg[k][0]) + ACC_W'(prod_reg[k][1])
                        + ACC_W'(prod_reg[k][2]) - ACC_W'(prod_reg[k][3]);
        end
        acc_next[IDX_W] = ACC_W'(prod_reg[IDX_W][0]) - ACC_W'(prod_reg[IDX_W][1])
                        - ACC_W'(prod_reg[IDX_W][2]) - ACC_W'(prod_reg[IDX_W][3]);
    end

    // Stage 3: round half up, then clip to the component range
    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            rnd[k] = acc_reg[k] + RND_HALF;
            shr[k] = rnd[k] >>> FRAC_BITS;
            if ((&shr[k][ACC_W-1:COMP_W-1]) || !(|shr[k][ACC_W-1:COMP_W-1]))
            begin
                r_next[k]   = shr[k][COMP_W-1:0];
                sat_next[k] = 1'b0;
            end
            else
            begin
                r_next[k]   = shr[k][ACC_W-1] ? MIN_VAL : MAX_VAL;
                sat_next[k] = 1'b1;
            end
        end
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_valid_reg <= 1'b0;
            sum_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            mul_valid_reg <= in_valid;
            sum_valid_reg <= mul_valid_reg;
            out_valid_reg <= sum_valid_reg;
        end
    end

    // Data path registers
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= prod_next;
            acc_reg  <= acc_next;
            r_reg    <= r_next;
            sat_reg  <= sat_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign r         = r_reg;
    assign sat       = sat_reg;

endmodule

>>> test/tb.sv
`timescale 1ns / 1ps

module tb;
    import qpr_pkg::*;

    localparam int QUIET_LIMIT = 1000;
    localparam int HOLD_STRETCH = 150;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cmd_valid = 1'b0;
    logic cmd_ready;
    cmd_t cmd = '0;
    logic res_valid;
    logic res_ready = 1'b0;
    res_t res;

    cmd_t pending_cmds[$];
    res_t awaited_results[$];

    bit cmd_fire = 1'b0;
    bit res_fire = 1'b0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_cycles = 0;
    int quiet_cycles = 0;
    int mismatch_count = 0;

    quaternion_product_and_rotate u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    always #6 clk = ~clk;

    // Round to nearest (ties up), then clip to the component range
    function automatic longint round_sat(longint acc, inout bit clipped);
        longint v;
        v = (acc + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
        if (v > (longint'(1) <<< (COMP_W - 1)) - 1)
        begin
            clipped = 1'b1;
            v = (longint'(1) <<< (COMP_W - 1)) - 1;
        end
        else if (v < -(longint'(1) <<< (COMP_W - 1)))
        begin
            clipped = 1'b1;
            v = -(longint'(1) <<< (COMP_W - 1));
        end
        return v;
    endfunction

    // Exact sum of products for one component of the Hamilton product p*q
    function automatic longint ham_comp(int idx, longint px, longint py, longint pz,
                                        longint pw, longint qx, longint qy,
                                        longint qz, longint qw);
        case (idx)
            IDX_X:   return pw * qx + px * qw + py * qz - pz * qy;
            IDX_Y:   return pw * qy + py * qw + pz * qx - px * qz;
            IDX_Z:   return pw * qz + pz * qw + px * qy - py * qx;
            default: return pw * qw - px * qx - py * qy - pz * qz;
        endcase
    endfunction

    // Expected result for one command
    function automatic res_t quat_result_of(cmd_t c);
        longint ax, ay, az, aw, bx, by, bz, bw;
        longint tx, ty, tz, tw;
        bit clipped;
        res_t r;
        ax = c.a_x;
        ay = c.a_y;
        az = c.a_z;
        aw = c.a_w;
        bx = c.b_x;
        by = c.b_y;
        bz = c.b_z;
        bw = c.b_w;
        clipped = 1'b0;
        if (c.op == OP_PRODUCT)
        begin
            r.r_x = comp_t'(round_sat(ham_comp(IDX_X, ax, ay, az, aw, bx, by, bz, bw), clipped));
            r.r_y = comp_t'(round_sat(ham_comp(IDX_Y, ax, ay, az, aw, bx, by, bz, bw), clipped));
            r.r_z = comp_t'(round_sat(ham_comp(IDX_Z, ax, ay, az, aw, bx, by, bz, bw), clipped));
            r.r_w = comp_t'(round_sat(ham_comp(IDX_W, ax, ay, az, aw, bx, by, bz, bw), clipped));
        end
        else
        begin
            // t = a * (v, 0), all four parts rounded and clipped
            tx = round_sat(ham_comp(IDX_X, ax, ay, az, aw, bx, by, bz, 0), clipped);
            ty = round_sat(ham_comp(IDX_Y, ax, ay, az, aw, bx, by, bz, 0), clipped);
            tz = round_sat(ham_comp(IDX_Z, ax, ay, az, aw, bx, by, bz, 0), clipped);
            tw = round_sat(ham_comp(IDX_W, ax, ay, az, aw, bx, by, bz, 0), clipped);
            // r = t * conj(a); the scalar part is dropped and cannot flag
            r.r_x = comp_t'(round_sat(ham_comp(IDX_X, tx, ty, tz, tw, -ax, -ay, -az, aw),
                                      clipped));
            r.r_y = comp_t'(round_sat(ham_comp(IDX_Y, tx, ty, tz, tw, -ax, -ay, -az, aw),
                                      clipped));
            r.r_z = comp_t'(round_sat(ham_comp(IDX_Z, tx, ty, tz, tw, -ax, -ay, -az, aw),
                                      clipped));
            r.r_w = '0;
        end
        r.saturated = clipped;
        return r;
    endfunction

    function automatic cmd_t mk_cmd(logic op, comp_t ax, comp_t ay, comp_t az, comp_t aw,
                                    comp_t bx, comp_t by, comp_t bz, comp_t bw);
        cmd_t c;
        c.op = op;
        c.a_x = ax;
        c.a_y = ay;
        c.a_z = az;
        c.a_w = aw;
        c.b_x = bx;
        c.b_y = by;
        c.b_z = bz;
        c.b_w = bw;
        return c;
    endfunction

    // Component draw: mostly near-unit values, some full range, some corners
    function automatic comp_t rand_comp(int unsigned style);
        int unsigned pick;
        pick = (style < 9) ? style : $urandom_range(9);
        if (pick < 5)
            return comp_t'(int'($urandom_range(32768)) - 16384);
        else if (pick < 8)
            return comp_t'($urandom);
        case ($urandom_range(6))
            0:       return comp_t'(-32768);
            1:       return comp_t'(32767);
            2:       return comp_t'(0);
            3:       return comp_t'(-1);
            4:       return comp_t'(1);
            5:       return comp_t'(16384);
            default: return comp_t'(-16384);
        endcase
    endfunction

    function automatic cmd_t rand_cmd();
        int unsigned style;
        cmd_t c;
        style = $urandom_range(10);
        c.op = $urandom_range(1) ? OP_ROTATE : OP_PRODUCT;
        c.a_x = rand_comp(style);
        c.a_y = rand_comp(style);
        c.a_z = rand_comp(style);
        c.a_w = rand_comp(style);
        c.b_x = rand_comp(style);
        c.b_y = rand_comp(style);
        c.b_z = rand_comp(style);
        c.b_w = rand_comp(style);
        return c;
    endfunction

    task automatic check_field(string name, logic [COMP_W-1:0] want, logic [COMP_W-1:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, actual %0d", name, $signed(want), $signed(got));
            mismatch_count++;
        end
    endtask

    // Queue n random commands under the given idling, then wait for all results
    task automatic run_phase(int n, int send_pct, int stall_pct);
        send_idle_pct = send_pct;
        recv_stall_pct = stall_pct;
        repeat (n) pending_cmds.push_back(rand_cmd());
        while (pending_cmds.size() != 0 || cmd_valid || awaited_results.size() != 0)
            @(posedge clk);
    endtask

    // Command driver
    always @(negedge clk)
    begin
        if (rst_n && (!cmd_valid || cmd_fire))
        begin
            if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                cmd <= pending_cmds.pop_front();
                cmd_valid <= 1'b1;
            end
            else
            begin
                cmd_valid <= 1'b0;
            end
        end
    end

    // Result receiver, with an optional long hold-off
    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            hold_cycles--;
            res_ready <= 1'b0;
        end
        else
        begin
            res_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Transaction monitor, checker and watchdog
    always @(posedge clk)
    begin : result_monitor
        res_t want;
        cmd_fire = cmd_valid && cmd_ready;
        res_fire = res_valid && res_ready;
        if (cmd_fire)
            awaited_results.push_back(quat_result_of(cmd));
        if (res_fire)
        begin
            if (awaited_results.size() == 0)
            begin
                $error("unexpected result transaction");
                mismatch_count++;
            end
            else
            begin
                want = awaited_results.pop_front();
                check_field("r_x", want.r_x, res.r_x);
                check_field("r_y", want.r_y, res.r_y);
                check_field("r_z", want.r_z, res.r_z);
                check_field("r_w", want.r_w, res.r_w);
                check_field("saturated", COMP_W'(want.saturated), COMP_W'(res.saturated));
            end
        end
        if (cmd_fire || res_fire)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("tb: FAIL");
            $finish;
        end
    end

    initial
    begin
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;

        // Directed: corners, both operations, rounding ties, clipping paths
        pending_cmds.push_back(mk_cmd(OP_PRODUCT, 0, 0, 0, 0, 0, 0, 0, 0));
        pending_cmds.push_back(mk_cmd(OP_PRODUCT, 0, 0, 0, 16384, 1000, -2000, 3000, -4000));
        pending_cmds.push_back(mk_cmd(OP_PRODUCT, 32767, 32767, 32767, 32767,
                                      32767, 32767, 32767, 32767));
        pending_cmds.push_back(mk_cmd(OP_PRODUCT, -32768, -32768, -32768, -32768,
                                      -32768, -32768, -32768, -32768));
        pending_cmds.push_back(mk_cmd(OP_PRODUCT, -32768, -32768, -32768, -32768,
                                      32767, 32767, 32767, 32767));
        pending_cmds.push_back(mk_cmd(OP_PRODUCT, 32767, 32767, 32767, -32768,
                                      -32768, -32768, -32768, 32767));
        // ties: +0.5 and +1.5 go up, -0.5 and -1.5 go up too
        pending_cmds.push_back(mk_cmd(OP_PRODUCT, 0, 0, 0, 1, 8192, 0, 0, 0));
        pending_cmds.push_back(mk_cmd(OP_PRODUCT, 0, 0, 0, -1, 8192, 0, 0, 0));
        pending_cmds.push_back(mk_cmd(OP_PRODUCT, 0, 0, 0, 3, 8192, 0, 0, 0));
        pending_cmds.push_back(mk_cmd(OP_PRODUCT, 0, 0, 0, -3, 8192, 0, 0, 0));
        // rotations; b_w must not matter
        pending_cmds.push_back(mk_cmd(OP_ROTATE, 0, 0, 0, 16384, 5000, -6000, 7000, 12345));
        pending_cmds.push_back(mk_cmd(OP_ROTATE, 0, 0, 11585, 11585, 16384, 0, 0, -32768));
        pending_cmds.push_back(mk_cmd(OP_ROTATE, 8192, 8192, 8192, 8192, 16384, 0, 0, 0));
        // conjugate of the most negative component
        pending_cmds.push_back(mk_cmd(OP_ROTATE, -32768, -32768, -32768, -32768, 1, 2, 3, 0));
        pending_cmds.push_back(mk_cmd(OP_ROTATE, -32768, 0, 0, 0, 16384, 16384, 16384, 32767));
        pending_cmds.push_back(mk_cmd(OP_ROTATE, 32767, 32767, 32767, 32767,
                                      32767, 32767, 32767, 32767));
        pending_cmds.push_back(mk_cmd(OP_ROTATE, -32768, -32768, -32768, -32768,
                                      -32768, -32768, -32768, -32768));
        // intermediate fits, final x rounds to the largest value without clipping
        pending_cmds.push_back(mk_cmd(OP_ROTATE, 0, 0, 0, 23170, 16384, 0, 0, 0));
        pending_cmds.push_back(mk_cmd(OP_ROTATE, -1, -1, -1, -1, -1, -1, -1, -1));
        pending_cmds.push_back(mk_cmd(OP_ROTATE, 0, 0, 0, 0, 0, 0, 0, -32768));
        run_phase(0, 0, 0);

        // Random phases across the idling mixes
        run_phase(400, 0, 0);
        run_phase(350, 55, 0);
        run_phase(350, 0, 55);
        run_phase(300, 19, 19);

        // Receiver holds off while the sender keeps pushing
        @(posedge clk);
        hold_cycles = HOLD_STRETCH;
        run_phase(150, 0, 0);

        repeat (12) @(posedge clk);
        if (awaited_results.size() != 0)
        begin
            $error("%0d expected results never arrived", awaited_results.size());
            mismatch_count++;
        end
        if (mismatch_count == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end
endmodule
